/* rtl/core/prl_pkg.sv */
// ----------------------------------------------------------------------------
// prl_pkg: shared types, constants and table math for the page reuse scorer
// Feature layout, register codes and the elaboration-time sigmoid entry.
// ----------------------------------------------------------------------------
package prl_pkg;

   localparam int unsigned FEATURE_COUNT               = 7;
   localparam int unsigned SIGMOID_TABLE_DEPTH_DEFAULT = 1024;

   localparam int unsigned WEIGHT_W    = 24;
   localparam int unsigned BIAS_W      = 32;
   localparam int unsigned FEAT_W      = 20;
   localparam int unsigned PROD_W      = FEAT_W + 1 + WEIGHT_W;
   localparam int unsigned SCORE_W     = 48;
   localparam int unsigned ZC_W        = 20;
   localparam int unsigned PROB_W      = 16;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned AVG_SHIFT   = 4;

   localparam int unsigned FEAT_FREQ_SHORT  = 0;
   localparam int unsigned FEAT_FREQ_MID    = 1;
   localparam int unsigned FEAT_FREQ_LONG   = 2;
   localparam int unsigned FEAT_RECENCY     = 3;
   localparam int unsigned FEAT_LAST_REUSE  = 4;
   localparam int unsigned FEAT_AVG_REUSE   = 5;
   localparam int unsigned FEAT_REUSE_COUNT = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_W_FREQ_SHORT  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_W_FREQ_MID    = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_W_FREQ_LONG   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_W_RECENCY     = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_W_LAST_REUSE  = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_W_AVG_REUSE   = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_W_REUSE_COUNT = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS          = 4'd7;

   localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

   typedef struct packed {
      logic [7:0]  freq_short;
      logic [7:0]  freq_mid;
      logic [7:0]  freq_long;
      logic [15:0] recency;
      logic [15:0] last_reuse_dist;
      logic [19:0] avg_reuse_dist;
      logic [15:0] reuse_hits;
   } feature_type;

   typedef logic [FEATURE_COUNT-1:0][WEIGHT_W-1:0] weight_vec_type;

   // unsigned feature times signed weight, sign-extended to score width
   function automatic logic signed [SCORE_W-1:0] feature_product(
      input logic [FEAT_W-1:0]   x,
      input logic [WEIGHT_W-1:0] w
   );
      logic signed [PROD_W-1:0] p;
      p = $signed({1'b0, x}) * $signed(w);
      return SCORE_W'(p);
   endfunction

   // shift-subtract quotient, elaboration use only
   function automatic logic [63:0] udiv64(
      input logic [63:0] num,
      input logic [63:0] den
   );
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sigmoid at the midpoint of entry idx, Q0.16
   function automatic logic [PROB_W-1:0] sigmoid_entry(
      input int unsigned idx,
      input int unsigned depth
   );
      logic [63:0]        dep;
      logic [63:0]        twice;
      logic [63:0]        gap;
      logic [63:0]        u;
      logic [63:0]        term;
      logic [63:0]        r;
      logic [63:0]        den;
      logic [63:0]        p;
      logic signed [63:0] sum;
      logic               nonneg;
      dep    = 64'(depth);
      twice  = (64'(idx) << 1) | 64'd1;
      nonneg = (twice >= dep);
      gap    = nonneg ? (twice - dep) : (dep - twice);
      u      = udiv64(gap << 30, dep);
      term   = ONE_Q31;
      sum    = $signed(ONE_Q31);
      for (int n = 1; n <= 24; n++) begin
         term = udiv64((term * u) >> 31, 64'(n));
         if ((n & 1) != 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      r = $unsigned(sum);
      if (r > ONE_Q31) begin
         r = ONE_Q31;
      end
      for (int k = 0; k < 4; k++) begin
         r = (r * r + (ONE_Q31 >> 1)) >> 31;
      end
      den = ONE_Q31 + r;
      if (nonneg) begin
         p = udiv64((64'd1 << 47) + (den >> 1), den);
      end else begin
         p = udiv64((r << 16) + (den >> 1), den);
      end
      if (p > 64'd65535) begin
         p = 64'd65535;
      end
      return p[PROB_W-1:0];
   endfunction

endpackage

/* rtl/core/prl_req_if.sv */
// ----------------------------------------------------------------------------
// prl_req_if: feature request channel
// Valid/ready channel carrying the seven page-access features of one beat.
// ----------------------------------------------------------------------------
interface prl_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  freq_short;
   logic [7:0]  freq_mid;
   logic [7:0]  freq_long;
   logic [15:0] recency;
   logic [15:0] last_reuse_dist;
   logic [19:0] avg_reuse_dist;
   logic [15:0] reuse_hits;

   modport source (
      output valid, freq_short, freq_mid, freq_long, recency,
             last_reuse_dist, avg_reuse_dist, reuse_hits,
      input  ready
   );
   modport sink (
      input  valid, freq_short, freq_mid, freq_long, recency,
             last_reuse_dist, avg_reuse_dist, reuse_hits,
      output ready
   );
endinterface

/* rtl/core/prl_rsp_if.sv */
// ----------------------------------------------------------------------------
// prl_rsp_if: score response channel
// Valid/ready channel carrying the reuse probability and decision of one beat.
// ----------------------------------------------------------------------------
interface prl_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] reuse_probability;
   logic        reuse_predicted;

   modport source (
      output valid, reuse_probability, reuse_predicted,
      input  ready
   );
   modport sink (
      input  valid, reuse_probability, reuse_predicted,
      output ready
   );
endinterface

/* rtl/core/prl_csr_if.sv */
// ----------------------------------------------------------------------------
// prl_csr_if: register write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface prl_csr_if;
   logic                               valid;
   logic                               ready;
   logic [prl_pkg::CSR_INDEX_W-1:0]    index;
   logic [prl_pkg::CSR_DATA_W-1:0]     data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

/* rtl/core/page_reuse_logistic_scorer.sv */
// ----------------------------------------------------------------------------
// page_reuse_logistic_scorer: logistic reuse score for one page per beat
// Dot product of seven features with folded weights, sign decision, sigmoid.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  - one beat of seven page-access features.
//   rsp_ch  - one beat per request: reuse_probability (Q0.16 sigmoid of the
//             score) and reuse_predicted (score >= 0).
//   csr_ch  - register writes, index 0..6 weights, 7 bias; other indexes drop.
//             Always ready; write only while no request is in flight.
// Throughput: one beat per cycle while rsp_ch is not held.
// Pipeline: the path has six register stages: input, products, partial sums,
//   score, table index, table read.
// Stall: all stages advance together when the output stage is empty or the
//   receiver takes it; while rsp_ch is held, req_ch.ready stays low and every
//   stage holds.
// Reset: clears all stage valids and sets weights and bias to zero.
// ----------------------------------------------------------------------------
module page_reuse_logistic_scorer #(
   parameter int unsigned SIGMOID_TABLE_DEPTH = prl_pkg::SIGMOID_TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   prl_req_if.sink     req_ch,
   prl_rsp_if.source   rsp_ch,
   prl_csr_if.sink     csr_ch
);
   import prl_pkg::*;

   localparam int unsigned STAGES    = 6;
   localparam int unsigned IDX_STAGE = 4;

   logic [STAGES-1:0]          stage_valid_ff;
   logic [STAGES-1:0]          stage_valid_in;
   logic                       advance;
   feature_type                feat_ff;
   feature_type                feat_in;
   weight_vec_type             weights;
   logic [BIAS_W-1:0]          bias;
   logic signed [SCORE_W-1:0]  score;

   assign advance      = ~stage_valid_ff[STAGES-1] | rsp_ch.ready;
   assign req_ch.ready = advance;

   assign stage_valid_in = advance ? {stage_valid_ff[STAGES-2:0], req_ch.valid}
                                   : stage_valid_ff;

   always_comb begin
      feat_in.freq_short      = req_ch.freq_short;
      feat_in.freq_mid        = req_ch.freq_mid;
      feat_in.freq_long       = req_ch.freq_long;
      feat_in.recency         = req_ch.recency;
      feat_in.last_reuse_dist = req_ch.last_reuse_dist;
      feat_in.avg_reuse_dist  = req_ch.avg_reuse_dist;
      feat_in.reuse_hits      = req_ch.reuse_hits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         feat_ff <= feat_in;
      end
   end

   prl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .weights (weights),
      .bias    (bias)
   );

   prl_dot u_dot (
      .clock   (clock),
      .advance (advance),
      .feat    (feat_ff),
      .weights (weights),
      .bias    (bias),
      .score   (score)
   );

   prl_sig #(
      .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
   ) u_sig (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .index_valid       (stage_valid_ff[IDX_STAGE]),
      .score             (score),
      .reuse_probability (rsp_ch.reuse_probability),
      .reuse_predicted   (rsp_ch.reuse_predicted)
   );

   assign rsp_ch.valid = stage_valid_ff[STAGES-1];

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (stage_valid_ff == '0))
      else $error("pipeline not empty after reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage_valid_ff))
      else $error("stage valids moved during stall");

   a_block_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while output stalled");

endmodule

/* rtl/core/prl_csr.sv */
// ----------------------------------------------------------------------------
// prl_csr: weight and bias registers
// Holds the seven folded weights and the folded bias; unknown indexes drop.
// ----------------------------------------------------------------------------
module prl_csr (
   input  logic                                clock,
   input  logic                                reset,
   prl_csr_if.sink                             csr_ch,
   output prl_pkg::weight_vec_type             weights,
   output logic [prl_pkg::BIAS_W-1:0]          bias
);
   import prl_pkg::*;

   weight_vec_type      weight_ff;
   weight_vec_type      weight_in;
   logic [BIAS_W-1:0]   bias_ff;
   logic [BIAS_W-1:0]   bias_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      weight_in = weight_ff;
      bias_in   = bias_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_W_FREQ_SHORT:  weight_in[FEAT_FREQ_SHORT]  = csr_ch.data[WEIGHT_W-1:0];
            CSR_W_FREQ_MID:    weight_in[FEAT_FREQ_MID]    = csr_ch.data[WEIGHT_W-1:0];
            CSR_W_FREQ_LONG:   weight_in[FEAT_FREQ_LONG]   = csr_ch.data[WEIGHT_W-1:0];
            CSR_W_RECENCY:     weight_in[FEAT_RECENCY]     = csr_ch.data[WEIGHT_W-1:0];
            CSR_W_LAST_REUSE:  weight_in[FEAT_LAST_REUSE]  = csr_ch.data[WEIGHT_W-1:0];
            CSR_W_AVG_REUSE:   weight_in[FEAT_AVG_REUSE]   = csr_ch.data[WEIGHT_W-1:0];
            CSR_W_REUSE_COUNT: weight_in[FEAT_REUSE_COUNT] = csr_ch.data[WEIGHT_W-1:0];
            CSR_BIAS:          bias_in = csr_ch.data[BIAS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
         bias_ff   <= '0;
      end else begin
         weight_ff <= weight_in;
         bias_ff   <= bias_in;
      end
   end

   assign weights = weight_ff;
   assign bias    = bias_ff;

endmodule

/* rtl/core/prl_dot.sv */
// ----------------------------------------------------------------------------
// prl_dot: folded dot product
// Seven products in one stage, two partial sums in the next, the score last.
// ----------------------------------------------------------------------------
module prl_dot (
   input  logic                                  clock,
   input  logic                                  advance,
   input  prl_pkg::feature_type                  feat,
   input  prl_pkg::weight_vec_type               weights,
   input  logic [prl_pkg::BIAS_W-1:0]            bias,
   output logic signed [prl_pkg::SCORE_W-1:0]    score
);
   import prl_pkg::*;

   logic [FEAT_W-1:0]          feat_vec [FEATURE_COUNT];
   logic signed [SCORE_W-1:0]  prod_in  [FEATURE_COUNT];
   logic signed [SCORE_W-1:0]  prod_ff  [FEATURE_COUNT];
   logic signed [SCORE_W-1:0]  bias_in;
   logic signed [SCORE_W-1:0]  bias_ff;
   logic signed [SCORE_W-1:0]  half_in  [2];
   logic signed [SCORE_W-1:0]  half_ff  [2];
   logic signed [SCORE_W-1:0]  score_in;
   logic signed [SCORE_W-1:0]  score_ff;

   always_comb begin
      feat_vec[FEAT_FREQ_SHORT]  = FEAT_W'(feat.freq_short);
      feat_vec[FEAT_FREQ_MID]    = FEAT_W'(feat.freq_mid);
      feat_vec[FEAT_FREQ_LONG]   = FEAT_W'(feat.freq_long);
      feat_vec[FEAT_RECENCY]     = FEAT_W'(feat.recency);
      feat_vec[FEAT_LAST_REUSE]  = FEAT_W'(feat.last_reuse_dist);
      feat_vec[FEAT_AVG_REUSE]   = feat.avg_reuse_dist;
      feat_vec[FEAT_REUSE_COUNT] = FEAT_W'(feat.reuse_hits);
   end

   // Q.4 feature: floor back to Q.16
   always_comb begin
      for (int f = 0; f < FEATURE_COUNT; f++) begin
         prod_in[f] = feature_product(feat_vec[f], weights[f]);
         if (f == FEAT_AVG_REUSE) begin
            prod_in[f] = prod_in[f] >>> AVG_SHIFT;
         end
      end
   end

   assign bias_in    = SCORE_W'($signed(bias));
   assign half_in[0] = prod_ff[FEAT_FREQ_SHORT] + prod_ff[FEAT_FREQ_MID]
                     + prod_ff[FEAT_FREQ_LONG] + prod_ff[FEAT_RECENCY];
   assign half_in[1] = prod_ff[FEAT_LAST_REUSE] + prod_ff[FEAT_AVG_REUSE]
                     + prod_ff[FEAT_REUSE_COUNT] + bias_ff;
   assign score_in   = half_ff[0] + half_ff[1];

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         bias_ff  <= bias_in;
         half_ff  <= half_in;
         score_ff <= score_in;
      end
   end

   assign score = score_ff;

endmodule

/* rtl/core/prl_sig.sv */
// ----------------------------------------------------------------------------
// prl_sig: score decision and sigmoid lookup
// Clamp the score to the table span, scale to an index, read the table.
// ----------------------------------------------------------------------------
module prl_sig #(
   parameter int unsigned SIGMOID_TABLE_DEPTH = prl_pkg::SIGMOID_TABLE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  index_valid,
   input  logic signed [prl_pkg::SCORE_W-1:0]    score,
   output logic [prl_pkg::PROB_W-1:0]            reuse_probability,
   output logic                                  reuse_predicted
);
   import prl_pkg::*;

   localparam int unsigned IDX_W   = $clog2(SIGMOID_TABLE_DEPTH);
   localparam int unsigned SCALE_W = ZC_W + $clog2(SIGMOID_TABLE_DEPTH + 1);
   localparam int unsigned HALF_LO = SIGMOID_TABLE_DEPTH / 2;
   localparam int unsigned HALF_HI = (SIGMOID_TABLE_DEPTH + 1) / 2;

   logic [PROB_W-1:0]   rom_table [SIGMOID_TABLE_DEPTH];
   logic                hi_zero;
   logic                hi_ones;
   logic [ZC_W-1:0]     offset;
   logic [SCALE_W-1:0]  scaled;
   logic [IDX_W-1:0]    idx_in;
   logic [IDX_W-1:0]    idx_ff;
   logic                pred_in;
   logic                pred_ff;
   logic [PROB_W-1:0]   prob_ff;
   logic                out_pred_ff;

   for (genvar i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin : g_rom
      localparam logic [PROB_W-1:0] ENTRY = sigmoid_entry(i, SIGMOID_TABLE_DEPTH);
      assign rom_table[i] = ENTRY;
   end

   // saturate to [-8, 8) and bias by +8 in one step
   always_comb begin
      hi_zero = ~|score[SCORE_W-2:ZC_W-1];
      hi_ones = &score[SCORE_W-2:ZC_W-1];
      pred_in = ~score[SCORE_W-1];
      if (pred_in) begin
         offset = hi_zero ? {1'b1, score[ZC_W-2:0]} : '1;
      end else begin
         offset = hi_ones ? {1'b0, score[ZC_W-2:0]} : '0;
      end
      scaled = SCALE_W'(offset) * SCALE_W'(SIGMOID_TABLE_DEPTH);
      idx_in = scaled[ZC_W +: IDX_W];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx_ff      <= idx_in;
         pred_ff     <= pred_in;
         prob_ff     <= rom_table[idx_ff];
         out_pred_ff <= pred_ff;
      end
   end

   assign reuse_probability = prob_ff;
   assign reuse_predicted   = out_pred_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      index_valid |-> (32'(idx_ff) < SIGMOID_TABLE_DEPTH))
      else $error("sigmoid index beyond table");

   a_idx_upper: assert property (@(posedge clock) disable iff (reset)
      index_valid && pred_ff |-> (32'(idx_ff) >= HALF_LO))
      else $error("nonnegative score indexed lower half");

   a_idx_lower: assert property (@(posedge clock) disable iff (reset)
      index_valid && !pred_ff |-> (32'(idx_ff) < HALF_HI))
      else $error("negative score indexed upper half");

endmodule
